>>> design/wfm_pkg.sv
package wfm_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_HEIGHT    = 1024;
  localparam int PIX_W         = 8;
  localparam int CH            = 3;
  localparam int TAPS          = 9;
  localparam int POS_W         = 10;
  localparam int DIM_W         = 13;
  localparam int CFG_DIM_W     = 11;
  localparam int COEF_W        = 24;
  localparam int PROD_W        = 17;
  localparam int ROW_W         = 19;
  localparam int SUM_W         = 20;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int APB_AW        = 5;
  localparam int APB_DW        = 32;
  localparam int MEDIAN_RANK   = 4;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  typedef enum logic [2:0] {
    REG_MODE,
    REG_COEF_TOP,
    REG_COEF_MID,
    REG_COEF_BOT,
    REG_WIDTH,
    REG_HEIGHT
  } reg_idx_e;

  typedef enum logic {
    MODE_CONV,
    MODE_MEDIAN
  } filter_mode_e;

  typedef logic [CH*PIX_W-1:0] pixel_t;

  typedef struct packed {
    filter_mode_e                  mode;
    logic [2:0][COEF_W-1:0]        coef;   // [0] top, [1] mid, [2] bottom
    logic [CFG_DIM_W-1:0]          width;
    logic [CFG_DIM_W-1:0]          height;
  } cfg_t;

  typedef struct packed {
    pixel_t [TAPS-1:0]   win;
    logic [POS_W-1:0]    col;
    logic [POS_W-1:0]    row;
    logic                last;
  } job_t;

  localparam int JOB_W = $bits(job_t);

endpackage

>>> design/wfm_pix_if.sv
interface wfm_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pix_c0;
  logic [7:0] pix_c1;
  logic [7:0] pix_c2;

  modport source (output valid, pix_c0, pix_c1, pix_c2, input ready);
  modport sink (input valid, pix_c0, pix_c1, pix_c2, output ready);
endinterface

>>> design/wfm_res_if.sv
interface wfm_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] res_c0;
  logic [7:0] res_c1;
  logic [7:0] res_c2;
  logic [9:0] center_col;
  logic [9:0] center_row;
  logic       frame_last;

  modport source (output valid, res_c0, res_c1, res_c2, center_col, center_row, frame_last,
                  input ready);
  modport sink (input valid, res_c0, res_c1, res_c2, center_col, center_row, frame_last,
                output ready);
endinterface

>>> design/window_filter_3x3_conv_median.sv
// 3x3 window filter, convolution with clip or median, three 8-bit channels.
// Input channel pix_i: one raster-order pixel per transfer (valid/ready).
// Output channel res_o: one filtered pixel per interior window center, with its
//   column, row and a frame_last flag; border positions produce no transfer.
// APB port: filter mode, three coefficient rows, frame width and height.
//   Write registers only while the block is idle.
// Throughput: one pixel per cycle, sustained, as long as res_o is taken.
// Path from input transfer to result valid: line store read at the transfer
//   edge, then window update/queue push, product stage, row-sum/median stage,
//   output register.
// The front keeps the line store and window and never stalls once a pixel is
//   taken; a 4-entry job queue decouples it from the arithmetic back end.
// When res_o stalls, the back end holds, the queue fills, and pix_i.ready
//   drops once the queue plus the in-flight pixel would not fit.
// Reset: counters, window and config return to defaults (identity kernel,
//   1024x1024, convolution mode). Line stores are not cleared: the first two
//   lines of a frame fill them before any read matters.
module window_filter_3x3_conv_median #(
  parameter int MAX_WIDTH = wfm_pkg::MAX_WIDTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  wfm_pix_if.sink                    pix_i,
  wfm_res_if.source                  res_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [wfm_pkg::APB_AW-1:0] paddr,
  input  logic [wfm_pkg::APB_DW-1:0] pwdata,
  output logic [wfm_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);

  wfm_pkg::cfg_t              cfg_q;
  wfm_pkg::reg_idx_e          reg_idx;
  logic                       cfg_wr;
  logic                       push, pop, q_empty;
  logic [wfm_pkg::QCNT_W-1:0] q_count;
  wfm_pkg::job_t              job_in, job_out;

  assign pready  = 1'b1;
  assign reg_idx = wfm_pkg::reg_idx_e'(paddr[4:2]);
  assign cfg_wr  = psel & penable & pwrite & pready;

  // config registers; writes past the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode   <= wfm_pkg::MODE_CONV;
      cfg_q.coef   <= {24'h000000, 24'h000100, 24'h000000};
      cfg_q.width  <= wfm_pkg::CFG_DIM_W'(1024);
      cfg_q.height <= wfm_pkg::CFG_DIM_W'(1024);
    end else if (cfg_wr) begin
      case (reg_idx)
        wfm_pkg::REG_MODE:     cfg_q.mode    <= wfm_pkg::filter_mode_e'(pwdata[0]);
        wfm_pkg::REG_COEF_TOP: cfg_q.coef[0] <= pwdata[23:0];
        wfm_pkg::REG_COEF_MID: cfg_q.coef[1] <= pwdata[23:0];
        wfm_pkg::REG_COEF_BOT: cfg_q.coef[2] <= pwdata[23:0];
        wfm_pkg::REG_WIDTH:    cfg_q.width   <= pwdata[10:0];
        wfm_pkg::REG_HEIGHT:   cfg_q.height  <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      wfm_pkg::REG_MODE:     prdata = wfm_pkg::APB_DW'(cfg_q.mode);
      wfm_pkg::REG_COEF_TOP: prdata = wfm_pkg::APB_DW'(cfg_q.coef[0]);
      wfm_pkg::REG_COEF_MID: prdata = wfm_pkg::APB_DW'(cfg_q.coef[1]);
      wfm_pkg::REG_COEF_BOT: prdata = wfm_pkg::APB_DW'(cfg_q.coef[2]);
      wfm_pkg::REG_WIDTH:    prdata = wfm_pkg::APB_DW'(cfg_q.width);
      wfm_pkg::REG_HEIGHT:   prdata = wfm_pkg::APB_DW'(cfg_q.height);
      default:               prdata = '0;
    endcase
  end

  // front: counters, line stores, window; emits one job per interior center
  wfm_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .pix_i     (pix_i),
    .q_count_i (q_count),
    .push_o    (push),
    .job_o     (job_in)
  );

  wfm_queue #(
    .WIDTH (wfm_pkg::JOB_W),
    .DEPTH (wfm_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (job_in),
    .pop_i   (pop),
    .rdata_o (job_out),
    .empty_o (q_empty),
    .count_o (q_count)
  );

  // back: products/compares, row sums/median, clip and output register
  wfm_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .job_i     (job_out),
    .q_empty_i (q_empty),
    .pop_o     (pop),
    .res_o     (res_o)
  );

endmodule

>>> design/wfm_ram.sv
module wfm_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/wfm_queue.sv
module wfm_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           wdata_i,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           rdata_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] buf_q [DEPTH];
  logic [PW-1:0]    wptr_q, rptr_q;
  logic [CW-1:0]    count_q;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) wptr_q <= bump(wptr_q);
      if (pop_i) rptr_q <= bump(rptr_q);
      if (push_i && !pop_i) count_q <= count_q + CW'(1);
      else if (pop_i && !push_i) count_q <= count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) buf_q[wptr_q] <= wdata_i;
  end

  assign rdata_o = buf_q[rptr_q];
  assign empty_o = (count_q == '0);
  assign count_o = count_q;

endmodule

>>> design/wfm_front.sv
module wfm_front #(
  parameter int MAX_WIDTH = wfm_pkg::MAX_WIDTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  wfm_pkg::cfg_t              cfg_i,
  wfm_pix_if.sink                    pix_i,
  input  logic [wfm_pkg::QCNT_W-1:0] q_count_i,
  output logic                       push_o,
  output wfm_pkg::job_t              job_o
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int DW = wfm_pkg::DIM_W;
  localparam int PW = wfm_pkg::POS_W;
  localparam int QW = wfm_pkg::QCNT_W;
  localparam int XW = wfm_pkg::CH * wfm_pkg::PIX_W;

  logic [DW-1:0] w_eff, h_eff;
  logic [PW-1:0] col_q, row_q;
  logic          col_end, row_end, accept;

  logic               s1_valid_q, s1_emit_q, s1_last_q;
  wfm_pkg::pixel_t    s1_pix_q;
  logic [AW-1:0]      s1_idx_q;
  logic [PW-1:0]      s1_col_q, s1_row_q;

  wfm_pkg::pixel_t [wfm_pkg::TAPS-1:0] win_q, win_d;
  logic [2*XW-1:0] rd_data;

  // saturate frame size
  always_comb begin
    w_eff = DW'(cfg_i.width);
    if (cfg_i.width < wfm_pkg::CFG_DIM_W'(3)) w_eff = DW'(3);
    else if (DW'(cfg_i.width) > DW'(MAX_WIDTH)) w_eff = DW'(MAX_WIDTH);
    h_eff = DW'(cfg_i.height);
    if (cfg_i.height < wfm_pkg::CFG_DIM_W'(3)) h_eff = DW'(3);
    else if (DW'(cfg_i.height) > DW'(wfm_pkg::MAX_HEIGHT)) h_eff = DW'(wfm_pkg::MAX_HEIGHT);
  end

  assign col_end = DW'(col_q) >= (w_eff - DW'(1));
  assign row_end = DW'(row_q) >= (h_eff - DW'(1));

  // room for the queue plus the item in the write-back stage
  assign pix_i.ready = (q_count_i + QW'(s1_valid_q)) < QW'(wfm_pkg::QUEUE_DEPTH);
  assign accept      = pix_i.valid & pix_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      if (accept) begin
        if (col_end) begin
          col_q <= '0;
          row_q <= row_end ? '0 : row_q + PW'(1);
        end else begin
          col_q <= col_q + PW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q  <= {pix_i.pix_c2, pix_i.pix_c1, pix_i.pix_c0};
      s1_idx_q  <= AW'(col_q);
      s1_emit_q <= (col_q >= PW'(2)) && (row_q >= PW'(2));
      s1_col_q  <= col_q - PW'(1);
      s1_row_q  <= row_q - PW'(1);
      s1_last_q <= col_end && row_end;
    end
  end

  // line stores: upper half previous line, lower half the line before it
  wfm_ram #(
    .WIDTH (2 * XW),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_idx_q),
    .wdata_i ({s1_pix_q, rd_data[2*XW-1:XW]}),
    .raddr_i (AW'(col_q)),
    .rdata_o (rd_data)
  );

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_d[r*3]     = win_q[r*3 + 1];
      win_d[r*3 + 1] = win_q[r*3 + 2];
    end
    win_d[2] = rd_data[XW-1:0];
    win_d[5] = rd_data[2*XW-1:XW];
    win_d[8] = s1_pix_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (s1_valid_q) begin
      win_q <= win_d;
    end
  end

  assign push_o    = s1_valid_q & s1_emit_q;
  assign job_o.win  = win_d;
  assign job_o.col  = s1_col_q;
  assign job_o.row  = s1_row_q;
  assign job_o.last = s1_last_q;

endmodule

>>> design/wfm_back.sv
module wfm_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  wfm_pkg::cfg_t cfg_i,
  input  wfm_pkg::job_t job_i,
  input  logic          q_empty_i,
  output logic          pop_o,
  wfm_res_if.source     res_o
);

  localparam int CH = wfm_pkg::CH;
  localparam int T  = wfm_pkg::TAPS;
  localparam int PX = wfm_pkg::PIX_W;
  localparam int PW = wfm_pkg::POS_W;

  logic en_o, en2, en1;

  // stage 1: products and compare matrix
  logic                               v1_q;
  wfm_pkg::filter_mode_e              mode1_q;
  logic [PW-1:0]                      col1_q, row1_q;
  logic                               last1_q;
  logic signed [wfm_pkg::PROD_W-1:0]  prod_d [CH][T];
  logic signed [wfm_pkg::PROD_W-1:0]  prod_q [CH][T];
  logic [T-1:0]                       lt_d [CH][T];
  logic [T-1:0]                       lt_q [CH][T];
  logic [PX-1:0]                      val_q [CH][T];

  // stage 2: row sums and median pick
  logic                               v2_q;
  wfm_pkg::filter_mode_e              mode2_q;
  logic [PW-1:0]                      col2_q, row2_q;
  logic                               last2_q;
  logic signed [wfm_pkg::ROW_W-1:0]   rs_d [CH][3];
  logic signed [wfm_pkg::ROW_W-1:0]   rs_q [CH][3];
  logic [PX-1:0]                      med_d [CH];
  logic [PX-1:0]                      med_q [CH];

  // output register
  logic                               out_v_q;
  logic [PX-1:0]                      res_d [CH];
  logic [PX-1:0]                      res_q [CH];
  logic [PW-1:0]                      col_o_q, row_o_q;
  logic                               last_o_q;

  assign en_o  = !out_v_q || res_o.ready;
  assign en2   = !v2_q || en_o;
  assign en1   = !v1_q || en2;
  assign pop_o = !q_empty_i && en1;

  always_comb begin
    logic [PX-1:0] ci;
    logic [PX-1:0] cj;
    for (int ch = 0; ch < CH; ch++) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_d[ch][r*3 + c] =
            $signed(cfg_i.coef[r][8*c +: 8]) *
            $signed({1'b0, job_i.win[r*3 + c][PX*ch +: PX]});
        end
      end
      for (int i = 0; i < T; i++) begin
        for (int j = 0; j < T; j++) begin
          ci = job_i.win[i][PX*ch +: PX];
          cj = job_i.win[j][PX*ch +: PX];
          lt_d[ch][i][j] = cj < ci;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (en1) v1_q <= pop_o;
      if (en2) v2_q <= v1_q;
      if (en_o) out_v_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      mode1_q <= cfg_i.mode;
      col1_q  <= job_i.col;
      row1_q  <= job_i.row;
      last1_q <= job_i.last;
      for (int ch = 0; ch < CH; ch++) begin
        for (int t = 0; t < T; t++) begin
          prod_q[ch][t] <= prod_d[ch][t];
          lt_q[ch][t]   <= lt_d[ch][t];
          val_q[ch][t]  <= job_i.win[t][PX*ch +: PX];
        end
      end
    end
  end

  always_comb begin
    logic [3:0] lt_n;
    logic [3:0] le_n;
    for (int ch = 0; ch < CH; ch++) begin
      for (int r = 0; r < 3; r++) begin
        rs_d[ch][r] = wfm_pkg::ROW_W'(prod_q[ch][r*3]) + wfm_pkg::ROW_W'(prod_q[ch][r*3 + 1])
                    + wfm_pkg::ROW_W'(prod_q[ch][r*3 + 2]);
      end
      // rank test: fewer than five below and at least five at or below
      med_d[ch] = '0;
      for (int i = T - 1; i >= 0; i--) begin
        lt_n = '0;
        le_n = '0;
        for (int j = 0; j < T; j++) begin
          lt_n = lt_n + 4'(lt_q[ch][i][j]);
          le_n = le_n + 4'(!lt_q[ch][j][i]);
        end
        if (lt_n <= 4'(wfm_pkg::MEDIAN_RANK) && le_n > 4'(wfm_pkg::MEDIAN_RANK)) begin
          med_d[ch] = val_q[ch][i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      mode2_q <= mode1_q;
      col2_q  <= col1_q;
      row2_q  <= row1_q;
      last2_q <= last1_q;
      rs_q    <= rs_d;
      med_q   <= med_d;
    end
  end

  always_comb begin
    logic signed [wfm_pkg::SUM_W-1:0] total;
    for (int ch = 0; ch < CH; ch++) begin
      total = wfm_pkg::SUM_W'(rs_q[ch][0]) + wfm_pkg::SUM_W'(rs_q[ch][1])
            + wfm_pkg::SUM_W'(rs_q[ch][2]);
      case (mode2_q)
        wfm_pkg::MODE_MEDIAN: res_d[ch] = med_q[ch];
        wfm_pkg::MODE_CONV: begin
          if (total < 0) res_d[ch] = '0;
          else if (total > wfm_pkg::SUM_W'(wfm_pkg::PIX_MAX)) res_d[ch] = wfm_pkg::PIX_MAX;
          else res_d[ch] = total[PX-1:0];
        end
        default: res_d[ch] = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o && v2_q) begin
      res_q    <= res_d;
      col_o_q  <= col2_q;
      row_o_q  <= row2_q;
      last_o_q <= last2_q;
    end
  end

  assign res_o.valid      = out_v_q;
  assign res_o.res_c0     = res_q[0];
  assign res_o.res_c1     = res_q[1];
  assign res_o.res_c2     = res_q[2];
  assign res_o.center_col = col_o_q;
  assign res_o.center_row = row_o_q;
  assign res_o.frame_last = last_o_q;

endmodule

>>> design/wfm_checker.sv
module wfm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       res_valid,
  input logic       res_ready,
  input logic [7:0] res_c0,
  input logic [7:0] res_c1,
  input logic [7:0] res_c2,
  input logic [9:0] center_col,
  input logic [9:0] center_row,
  input logic       frame_last,
  input logic       pready
);

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> $stable({res_c0, res_c1, res_c2, center_col, center_row,
                                         frame_last}))
    else $error("result changed while stalled");

  a_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> center_col != 10'd0 && center_row != 10'd0)
    else $error("border center produced a result");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind window_filter_3x3_conv_median wfm_checker u_wfm_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .res_valid  (res_o.valid),
  .res_ready  (res_o.ready),
  .res_c0     (res_o.res_c0),
  .res_c1     (res_o.res_c1),
  .res_c2     (res_o.res_c2),
  .center_col (res_o.center_col),
  .center_row (res_o.center_row),
  .frame_last (res_o.frame_last),
  .pready     (pready)
);
